[rtl/core/triangle_box_overlap_test_unit_macros.svh]
// Assertion macros shared by the overlap test RTL
`ifndef TRIANGLE_BOX_OVERLAP_TEST_UNIT_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define TBO_ASSERT_IMP(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the following cycle
`define TBO_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/tbo_pkg.sv]
package tbo_pkg;

   // Coordinate width and register index codes
   localparam int CoordWidth = 16;

   typedef enum logic [1:0] {
      REG_HALF_X = 2'd0,
      REG_HALF_Y = 2'd1,
      REG_HALF_Z = 2'd2
   } reg_index_type;

endpackage

[rtl/core/tbo_pipe.sv]
`include "triangle_box_overlap_test_unit_macros.svh"

module tbo_pipe #(
   parameter int CW = tbo_pkg::CoordWidth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] cen [3],
   input  logic signed [CW-1:0] vtx [3][3],
   input  logic        [CW-2:0] half [3],
   output logic                 out_valid,
   output logic                 out_hit
);
   localparam int VW = CW + 1;          // relative vertex
   localparam int EW = CW + 2;          // edge
   localparam int PW = VW + EW + 2;     // projection (difference of products)
   localparam int RW = EW + CW + 1;     // radius
   localparam int NW = 2 * EW + 2;      // normal component
   localparam int DW = CW + 2;          // corner minus vertex
   localparam int SW = NW + DW + 3;     // plane sum

   // stage enables: every stage moves when the head moves
   logic [5:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   // stage 1: relative vertices
   logic signed [VW-1:0] v1_ff [3][3];
   logic        [CW-2:0] h1_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            for (int q = 0; q < 3; q++) begin
               v1_ff[k][q] <= VW'(vtx[k][q]) - VW'(cen[q]);
            end
         end
         h1_ff <= half;
      end
   end

   // stage 2: edges, box-axis tests
   logic signed [VW-1:0] v2_ff [3][3];
   logic signed [EW-1:0] e2_ff [3][3];
   logic        [CW-2:0] h2_ff [3];
   logic                 box_sep2_ff;
   logic                 box_sep2_in;
   always_comb begin
      logic signed [VW-1:0] mn, mx;
      logic signed [VW:0]   hs;
      box_sep2_in = 1'b0;
      for (int q = 0; q < 3; q++) begin
         mn = v1_ff[0][q];
         mx = v1_ff[0][q];
         for (int k = 1; k < 3; k++) begin
            if (v1_ff[k][q] < mn) mn = v1_ff[k][q];
            if (v1_ff[k][q] > mx) mx = v1_ff[k][q];
         end
         hs = $signed({3'b000, h1_ff[q]});
         if ((VW+1)'(mn) > hs || (VW+1)'(mx) < -hs) box_sep2_in = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         v2_ff <= v1_ff;
         h2_ff <= h1_ff;
         box_sep2_ff <= box_sep2_in;
         for (int q = 0; q < 3; q++) begin
            e2_ff[0][q] <= EW'(v1_ff[1][q]) - EW'(v1_ff[0][q]);
            e2_ff[1][q] <= EW'(v1_ff[2][q]) - EW'(v1_ff[1][q]);
            e2_ff[2][q] <= EW'(v1_ff[0][q]) - EW'(v1_ff[2][q]);
         end
      end
   end

   // stage 3: products for the nine axis tests, radii, normal products
   // axis a of edge k: components (b,c) as in the cross product with unit axis
   logic signed [PW-2:0] pa3_ff [3][3][3];  // first product  [edge][axis][vertex]
   logic signed [PW-2:0] pb3_ff [3][3][3];  // second product
   logic        [RW-2:0] ra3_ff [3][3];
   logic        [RW-2:0] rb3_ff [3][3];
   logic signed [NW-2:0] na3_ff [3];
   logic signed [NW-2:0] nb3_ff [3];
   logic signed [VW-1:0] v03_ff [3];
   logic        [CW-2:0] h3_ff [3];
   logic                 box_sep3_ff;

   function automatic int idx_b(input int a);
      // component whose edge coefficient multiplies the first vertex term
      return (a == 0) ? 2 : (a == 1) ? 0 : 1;
   endfunction
   function automatic int idx_c(input int a);
      return (a == 0) ? 1 : (a == 1) ? 2 : 0;
   endfunction

   always_ff @(posedge clock) begin
      logic [EW-1:0] eab, eac;
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
               // p = e[b]*v[c] - e[c]*v[b] with (b,c) chosen per axis
               for (int m = 0; m < 3; m++) begin
                  pa3_ff[k][a][m] <= (PW-1)'(e2_ff[k][idx_b(a)]) *
                                     (PW-1)'(v2_ff[m][idx_c(a)]);
                  pb3_ff[k][a][m] <= (PW-1)'(e2_ff[k][idx_c(a)]) *
                                     (PW-1)'(v2_ff[m][idx_b(a)]);
               end
               // radius pairs each edge component with the other axis extent
               eab = e2_ff[k][idx_b(a)] < 0 ? EW'(-e2_ff[k][idx_b(a)])
                                            : EW'(e2_ff[k][idx_b(a)]);
               eac = e2_ff[k][idx_c(a)] < 0 ? EW'(-e2_ff[k][idx_c(a)])
                                            : EW'(e2_ff[k][idx_c(a)]);
               ra3_ff[k][a] <= (RW-1)'(eab) * (RW-1)'(h2_ff[idx_c(a)]);
               rb3_ff[k][a] <= (RW-1)'(eac) * (RW-1)'(h2_ff[idx_b(a)]);
            end
         end
         for (int q = 0; q < 3; q++) begin
            na3_ff[q] <= (NW-1)'(e2_ff[0][idx_c(q)]) * (NW-1)'(e2_ff[1][idx_b(q)]);
            nb3_ff[q] <= (NW-1)'(e2_ff[0][idx_b(q)]) * (NW-1)'(e2_ff[1][idx_c(q)]);
            v03_ff[q] <= v2_ff[0][q];
         end
         h3_ff <= h2_ff;
         box_sep3_ff <= box_sep2_ff;
      end
   end

   // stage 4: projections, radii, normal; edge separation decided
   logic signed [PW-1:0] p4 [3][3][3];
   logic signed [NW-1:0] n4_ff [3];
   logic signed [VW-1:0] v04_ff [3];
   logic        [CW-2:0] h4_ff [3];
   logic                 sep4_ff;
   logic                 sep4_in;
   always_comb begin
      logic signed [PW-1:0] mn, mx;
      logic signed [PW-1:0] rad;
      sep4_in = box_sep3_ff;
      for (int k = 0; k < 3; k++) begin
         for (int a = 0; a < 3; a++) begin
            for (int m = 0; m < 3; m++) begin
               p4[k][a][m] = PW'(pa3_ff[k][a][m]) - PW'(pb3_ff[k][a][m]);
            end
            mn = p4[k][a][0];
            mx = p4[k][a][0];
            for (int m = 1; m < 3; m++) begin
               if (p4[k][a][m] < mn) mn = p4[k][a][m];
               if (p4[k][a][m] > mx) mx = p4[k][a][m];
            end
            rad = $signed(PW'(ra3_ff[k][a])) + $signed(PW'(rb3_ff[k][a]));
            if (mn > rad || mx < -rad) sep4_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int q = 0; q < 3; q++) begin
            n4_ff[q] <= NW'(na3_ff[q]) - NW'(nb3_ff[q]);
         end
         v04_ff <= v03_ff;
         h4_ff <= h3_ff;
         sep4_ff <= sep4_in;
      end
   end

   // stage 5: plane products n*(near - v0) and n*(-near - v0)
   logic signed [SW-1:0] tmin5_ff [3];
   logic signed [SW-1:0] tmax5_ff [3];
   logic                 sep5_ff;
   always_ff @(posedge clock) begin
      logic signed [DW-1:0] nr, dmin, dmax;
      if (advance) begin
         for (int q = 0; q < 3; q++) begin
            nr = (n4_ff[q] > 0) ? -$signed(DW'(h4_ff[q])) : $signed(DW'(h4_ff[q]));
            dmin = nr - DW'(v04_ff[q]);
            dmax = -nr - DW'(v04_ff[q]);
            tmin5_ff[q] <= SW'(n4_ff[q]) * SW'(dmin);
            tmax5_ff[q] <= SW'(n4_ff[q]) * SW'(dmax);
         end
         sep5_ff <= sep4_ff;
      end
   end

   // stage 6: plane sums and final decision
   logic signed [SW-1:0] smin6, smax6;
   logic                 hit6_ff;
   assign smin6 = tmin5_ff[0] + tmin5_ff[1] + tmin5_ff[2];
   assign smax6 = tmax5_ff[0] + tmax5_ff[1] + tmax5_ff[2];
   always_ff @(posedge clock) begin
      if (advance) begin
         hit6_ff <= !sep5_ff && !(smin6 > 0) && !(smax6 < 0);
      end
   end

   assign out_valid = vld_ff[5];
   assign out_hit   = hit6_ff;

   `TBO_ASSERT_NEXT(a_vld_hold, clock, reset, !advance, vld_ff == $past(vld_ff))
   `TBO_ASSERT_NEXT(a_vld_shift, clock, reset, advance, vld_ff[1] == $past(vld_ff[0]))
   `TBO_ASSERT_NEXT(a_sep_kill, clock, reset, advance && sep5_ff, !hit6_ff)
endmodule

[rtl/core/triangle_box_overlap_test_unit.sv]
// Triangle / axis-aligned box overlap test, separating-axis method.
// req_ channel: one beat per triangle-box pair; tdata holds center x,y,z then
//   vertex 0 x,y,z, vertex 1, vertex 2, each COORD_WIDTH bits signed Q8.8,
//   lowest first. rsp_ channel: one beat per request, tdata bit 0 = overlap
//   (touching counts as overlap).
// csr_ port: index 0..2 writes half size x,y,z (unsigned, COORD_WIDTH-1 bits);
//   other indices are ignored. Write only while no pair is in flight.
// A request passes six pipeline stages and then the output register on its way to
//   rsp_tvalid. Throughput: one pair per cycle while the receiver does not stall.
// The pipeline advances whenever its last stage is empty or its result moves
//   into the output register; a skid-free output register takes a result
//   while the previous one is taken, so a stalled receiver, once a result waits
//   in the last stage, stops the whole pipeline without loss and req_tready falls.
// Reset clears all valid bits and sets each half size to 1.0.
// The widest signals are the plane products and sums of stages 5 and 6.
`include "triangle_box_overlap_test_unit_macros.svh"

module triangle_box_overlap_test_unit #(
   parameter int COORD_WIDTH = tbo_pkg::CoordWidth,
   localparam int DBW = ((12 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // center x,y,z, vert0 x,y,z, vert1 x,y,z, vert2 x,y,z; zero padded
   input  logic [DBW-1:0]         req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // overlap, zero padded
   output logic [7:0]             rsp_tdata,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [COORD_WIDTH-2:0] csr_wdata
);
   localparam int CW = COORD_WIDTH;

   // half-size registers
   logic [CW-2:0] half_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < 3; q++) half_ff[q] <= (CW-1)'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            tbo_pkg::REG_HALF_X: half_ff[0] <= csr_wdata;
            tbo_pkg::REG_HALF_Y: half_ff[1] <= csr_wdata;
            tbo_pkg::REG_HALF_Z: half_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // unpack request
   logic signed [CW-1:0] cen [3];
   logic signed [CW-1:0] vtx [3][3];
   always_comb begin
      for (int q = 0; q < 3; q++) begin
         cen[q] = req_tdata[q*CW +: CW];
         for (int k = 0; k < 3; k++) vtx[k][q] = req_tdata[(3 + 3*k + q)*CW +: CW];
      end
   end

   logic pipe_valid, pipe_hit, advance;
   logic out_valid_ff, out_hit_ff;

   // pipeline moves when its tail is free or drains into the output register
   assign advance    = !pipe_valid || !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   tbo_pipe #(.CW(CW)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .cen       (cen),
      .vtx       (vtx),
      .half      (half_ff),
      .out_valid (pipe_valid),
      .out_hit   (pipe_hit)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= pipe_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (pipe_valid && (!out_valid_ff || rsp_tready)) out_hit_ff <= pipe_hit;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_hit_ff};

   `TBO_ASSERT_IMP(a_no_drop, clock, reset, pipe_valid && advance, !out_valid_ff || rsp_tready)
   `TBO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TBO_ASSERT_IMP(a_ready_rule, clock, reset, !req_tready, pipe_valid && out_valid_ff)
endmodule
